@@ hdl/rdq_pkg.sv @@
package rdq_pkg;

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 5;
	localparam int OP_W     = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SORT       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SORT,
		S_DONE
	} seq_state_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		logic sort_step;
		logic phase;
	} cell_cmd_t;

endpackage

@@ hdl/rdq_cell.sv @@
module rdq_cell #(
	parameter int IDX   = 0,
	parameter int CW    = 5
) (
	input  logic                                clk,
	input  rdq_pkg::cell_cmd_t                  cmd,
	input  logic [CW-1:0]                       count,
	input  logic signed [rdq_pkg::KEY_W-1:0]    in_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]        in_handle,
	input  logic signed [rdq_pkg::KEY_W-1:0]    left_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]        left_handle,
	input  logic signed [rdq_pkg::KEY_W-1:0]    right_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]        right_handle,
	input  logic                                swap_left,
	output logic                                swap_right,
	output logic signed [rdq_pkg::KEY_W-1:0]    key,
	output logic [rdq_pkg::HANDLE_W-1:0]        handle
);

	localparam logic IDX_ODD = 1'(IDX % 2);

	logic signed [rdq_pkg::KEY_W-1:0] key_q;
	logic [rdq_pkg::HANDLE_W-1:0]     handle_q;
	logic                             is_left;

	// even phase pairs (0,1),(2,3)..; odd phase pairs (1,2),(3,4)..
	assign is_left    = (IDX_ODD == cmd.phase);
	assign swap_right = cmd.sort_step & is_left & (CW'(IDX + 1) < count) & (key_q > right_key);

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			key_q    <= left_key;
			handle_q <= left_handle;
		end else if (cmd.pop_front) begin
			key_q    <= right_key;
			handle_q <= right_handle;
		end else if (cmd.push_back && count == CW'(IDX)) begin
			key_q    <= in_key;
			handle_q <= in_handle;
		end else if (swap_right) begin
			key_q    <= right_key;
			handle_q <= right_handle;
		end else if (cmd.sort_step && !is_left && swap_left) begin
			key_q    <= left_key;
			handle_q <= left_handle;
		end
	end

	assign key    = key_q;
	assign handle = handle_q;

endmodule

@@ hdl/rdq_ctrl.sv @@
module rdq_ctrl #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rdq_pkg::OP_W-1:0]             opcode,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rdq_pkg::STATUS_W-1:0]         status,
	output logic signed [rdq_pkg::KEY_W-1:0]     popped_key,
	output logic [rdq_pkg::HANDLE_W-1:0]         popped_handle,
	output logic [rdq_pkg::TOTAL_W-1:0]          entry_total,
	input  logic signed [rdq_pkg::KEY_W-1:0]     front_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]         front_handle,
	input  logic signed [rdq_pkg::KEY_W-1:0]     back_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]         back_handle,
	output rdq_pkg::cell_cmd_t                   cmd,
	output logic [CW-1:0]                        count
);

	rdq_pkg::seq_state_t state_q, state_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic [CW-1:0] phase_q;
	logic          out_valid_q;
	logic [rdq_pkg::STATUS_W-1:0]     status_q;
	logic signed [rdq_pkg::KEY_W-1:0] pkey_q;
	logic [rdq_pkg::HANDLE_W-1:0]     phandle_q;
	logic [rdq_pkg::TOTAL_W-1:0]      total_q;

	logic out_free, acc, is_full, is_empty, long_sort, load;
	rdq_pkg::status_t                 res_status;
	logic signed [rdq_pkg::KEY_W-1:0] res_key;
	logic [rdq_pkg::HANDLE_W-1:0]     res_handle;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != rdq_pkg::S_IDLE) || !out_free;
	assign acc       = in_valid && !in_stall;
	assign is_full   = count_q >= CW'(DEPTH);
	assign is_empty  = count_q == '0;
	assign long_sort = (rdq_pkg::op_t'(opcode) == rdq_pkg::OP_SORT) && (count_q >= CW'(2));
	// a sort with two or more records held reports from the done state instead
	assign load      = (acc && !long_sort) || (state_q == rdq_pkg::S_DONE && out_free);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rdq_pkg::S_IDLE: begin
				if (acc && long_sort)
					state_nxt = rdq_pkg::S_SORT;
			end
			rdq_pkg::S_SORT: begin
				if (phase_q == CW'(count_q - CW'(1)))
					state_nxt = rdq_pkg::S_DONE;
			end
			rdq_pkg::S_DONE: begin
				if (out_free)
					state_nxt = rdq_pkg::S_IDLE;
			end
			default: state_nxt = rdq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		count_nxt  = count_q;
		res_status = rdq_pkg::ST_OK;
		res_key    = '0;
		res_handle = '0;
		if (acc) begin
			unique case (rdq_pkg::op_t'(opcode))
				rdq_pkg::OP_PUSH_FRONT: begin
					if (is_full) begin
						res_status = rdq_pkg::ST_FULL;
					end else begin
						cmd.push_front = 1'b1;
						count_nxt      = CW'(count_q + CW'(1));
					end
				end
				rdq_pkg::OP_PUSH_BACK: begin
					if (is_full) begin
						res_status = rdq_pkg::ST_FULL;
					end else begin
						cmd.push_back = 1'b1;
						count_nxt     = CW'(count_q + CW'(1));
					end
				end
				rdq_pkg::OP_POP_FRONT: begin
					if (is_empty) begin
						res_status = rdq_pkg::ST_EMPTY;
					end else begin
						cmd.pop_front = 1'b1;
						count_nxt     = CW'(count_q - CW'(1));
						res_key       = front_key;
						res_handle    = front_handle;
					end
				end
				rdq_pkg::OP_POP_BACK: begin
					if (is_empty) begin
						res_status = rdq_pkg::ST_EMPTY;
					end else begin
						count_nxt  = CW'(count_q - CW'(1));
						res_key    = back_key;
						res_handle = back_handle;
					end
				end
				default: begin
				end
			endcase
		end
		cmd.sort_step = (state_q == rdq_pkg::S_SORT);
		cmd.phase     = phase_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdq_pkg::S_IDLE;
			count_q     <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (state_q == rdq_pkg::S_SORT)
				phase_q <= CW'(phase_q + CW'(1));
			else
				phase_q <= '0;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= res_status;
			pkey_q    <= res_key;
			phandle_q <= res_handle;
			total_q   <= rdq_pkg::TOTAL_W'(count_nxt);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign popped_key    = pkey_q;
	assign popped_handle = phandle_q;
	assign entry_total   = total_q;
	assign count         = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count beyond depth");

	a_sort_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rdq_pkg::S_SORT |-> count_q >= CW'(2))
		else $error("sort pass on fewer than two records");

	a_sort_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != rdq_pkg::S_IDLE |=> count_q == $past(count_q))
		else $error("record count moved during sort");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		load && res_status == rdq_pkg::ST_FULL |=> count_q == $past(count_q))
		else $error("count changed on full push");
`endif

endmodule

@@ hdl/record_deque_with_key_sort.sv @@
// channel  | handshake            | fields
// ---------+----------------------+---------------------------------------------------
// input    | in_valid / in_stall  | opcode, record_key, record_handle
// output   | out_valid / out_stall| status, popped_key, popped_handle, entry_total
//
// push and pop items are accepted at one item per cycle when the output drains.
// a sort item is accepted, then runs one odd-even transposition phase per cycle
// over the cell row (count phases), then reports from the done state;
// it reports like a push when fewer than two records are held.
// intake stalls during a sort and whenever a result waits on a stalled output.
// reset clears the record count and the sequencer; record cells hold no reset value.
module record_deque_with_key_sort #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rdq_pkg::OP_W-1:0]            opcode,
	input  logic signed [rdq_pkg::KEY_W-1:0]    record_key,
	input  logic [rdq_pkg::HANDLE_W-1:0]        record_handle,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rdq_pkg::STATUS_W-1:0]        status,
	output logic signed [rdq_pkg::KEY_W-1:0]    popped_key,
	output logic [rdq_pkg::HANDLE_W-1:0]        popped_handle,
	output logic [rdq_pkg::TOTAL_W-1:0]         entry_total
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	rdq_pkg::cell_cmd_t cmd;
	logic [CW-1:0]      count;
	logic [IW-1:0]      back_idx;

	logic signed [rdq_pkg::KEY_W-1:0] key_w    [DEPTH];
	logic [rdq_pkg::HANDLE_W-1:0]     handle_w [DEPTH];
	logic                             swap_w   [DEPTH];

	assign back_idx = IW'(count - CW'(1));

	rdq_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.popped_key    (popped_key),
		.popped_handle (popped_handle),
		.entry_total   (entry_total),
		.front_key     (key_w[0]),
		.front_handle  (handle_w[0]),
		.back_key      (key_w[back_idx]),
		.back_handle   (handle_w[back_idx]),
		.cmd           (cmd),
		.count         (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [rdq_pkg::KEY_W-1:0] lk, rk;
		logic [rdq_pkg::HANDLE_W-1:0]     lh, rh;
		logic                             sl;

		// the front cell takes the new item from the left on a front push
		if (i == 0) begin : g_first
			assign lk = record_key;
			assign lh = record_handle;
			assign sl = 1'b0;
		end else begin : g_mid_l
			assign lk = key_w[i-1];
			assign lh = handle_w[i-1];
			assign sl = swap_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rk = '0;
			assign rh = '0;
		end else begin : g_mid_r
			assign rk = key_w[i+1];
			assign rh = handle_w[i+1];
		end

		rdq_cell #(
			.IDX   (i),
			.CW    (CW)
		) u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.count        (count),
			.in_key       (record_key),
			.in_handle    (record_handle),
			.left_key     (lk),
			.left_handle  (lh),
			.right_key    (rk),
			.right_handle (rh),
			.swap_left    (sl),
			.swap_right   (swap_w[i]),
			.key          (key_w[i]),
			.handle       (handle_w[i])
		);
	end

endmodule

@@ sim/rdq_tb_pkg.sv @@
package rdq_tb_pkg;

	import rdq_pkg::*;

	localparam int SLOTS = 16;

	typedef struct {
		logic [STATUS_W-1:0]        status;
		logic signed [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0]        handle;
		logic [TOTAL_W-1:0]         total;
	} deque_reply_t;

	// mirrors the record row and keeps the replies still owed by the block
	class deque_tracker;
		logic signed [KEY_W-1:0] key_row[SLOTS];
		logic [HANDLE_W-1:0]     handle_row[SLOTS];
		int                      held;
		deque_reply_t            awaited[$];
		int                      mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void note_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
			input logic [HANDLE_W-1:0] handle);
			deque_reply_t            r;
			bit                      moved;
			logic signed [KEY_W-1:0] tk;
			logic [HANDLE_W-1:0]     th;
			r.status = ST_OK;
			r.key = '0;
			r.handle = '0;
			case (op)
				OP_PUSH_FRONT: begin
					if (held >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						for (int i = held; i > 0; i--) begin
							key_row[i] = key_row[i-1];
							handle_row[i] = handle_row[i-1];
						end
						key_row[0] = key;
						handle_row[0] = handle;
						held++;
					end
				end
				OP_PUSH_BACK: begin
					if (held >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						key_row[held] = key;
						handle_row[held] = handle;
						held++;
					end
				end
				OP_POP_FRONT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.key = key_row[0];
						r.handle = handle_row[0];
						for (int i = 0; i + 1 < held; i++) begin
							key_row[i] = key_row[i+1];
							handle_row[i] = handle_row[i+1];
						end
						held--;
					end
				end
				OP_POP_BACK: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						held--;
						r.key = key_row[held];
						r.handle = handle_row[held];
					end
				end
				OP_SORT: begin
					// stable bubble: swap only on strictly greater key
					moved = (held >= 2);
					while (moved) begin
						moved = 0;
						for (int i = 0; i + 1 < held; i++) begin
							if (key_row[i] > key_row[i+1]) begin
								tk = key_row[i];
								th = handle_row[i];
								key_row[i] = key_row[i+1];
								handle_row[i] = handle_row[i+1];
								key_row[i+1] = tk;
								handle_row[i+1] = th;
								moved = 1;
							end
						end
					end
				end
				default: begin
				end
			endcase
			r.total = TOTAL_W'(held);
			awaited.push_back(r);
		endfunction

		function void check_result(input logic [STATUS_W-1:0] status,
			input logic signed [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle,
			input logic [TOTAL_W-1:0] total);
			deque_reply_t e;
			if (awaited.size() == 0) begin
				$error("result arrived with no item outstanding");
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (status !== e.status) begin
				$error("status mismatch: expected %0d, got %0d", e.status, status);
				mismatches++;
			end
			if (key !== e.key) begin
				$error("popped_key mismatch: expected %0d, got %0d", e.key, key);
				mismatches++;
			end
			if (handle !== e.handle) begin
				$error("popped_handle mismatch: expected 0x%04h, got 0x%04h", e.handle, handle);
				mismatches++;
			end
			if (total !== e.total) begin
				$error("entry_total mismatch: expected %0d, got %0d", e.total, total);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

endpackage

@@ sim/tb_top.sv @@
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import rdq_pkg::*;
	import rdq_tb_pkg::*;

	localparam int ITEM_COUNT   = 1750;
	localparam int DIRECTED     = 22;
	localparam int RAND_COUNT   = ITEM_COUNT - DIRECTED;
	localparam int CALM_TAIL    = 150;
	localparam int HOLD_AT      = 500;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {
		FILL_UP,
		DRAIN_DOWN,
		CHURN
	} traffic_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         opcode;
	logic signed [KEY_W-1:0] record_key;
	logic [HANDLE_W-1:0]     record_handle;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic signed [KEY_W-1:0] popped_key;
	logic [HANDLE_W-1:0]     popped_handle;
	logic [TOTAL_W-1:0]      entry_total;

	deque_tracker tracker = new();
	int           accepted_items = 0;
	bit           calm = 0;

	record_deque_with_key_sort #(
		.DEPTH(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.record_key(record_key),
		.record_handle(record_handle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.popped_key(popped_key),
		.popped_handle(popped_handle),
		.entry_total(entry_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
		input logic [HANDLE_W-1:0] handle);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		record_key <= key;
		record_handle <= handle;
		do @(posedge clk); while (in_stall);
		tracker.note_item(op, key, handle);
		accepted_items++;
	endtask

	initial begin : receiver
		int burst;
		bit held_off;
		burst = 0;
		held_off = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && accepted_items >= HOLD_AT) begin
				// long hold so a result waits and intake backs up
				held_off = 1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 5) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : result_monitor
		logic [STATUS_W-1:0]     st;
		logic signed [KEY_W-1:0] pk;
		logic [HANDLE_W-1:0]     ph;
		logic [TOTAL_W-1:0]      tot;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				st = status;
				pk = popped_key;
				ph = popped_handle;
				tot = entry_total;
				// let the sender note an item accepted on this same edge first
				#1;
				tracker.check_result(st, pk, ph, tot);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("record_deque_with_key_sort verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] key;
		logic [HANDLE_W-1:0]     handle;
		traffic_t                mode;
		int                      mode_left;
		int                      pick;
		int                      w_sort;
		int                      w_front;
		int                      w_back;
		int                      w_popf;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = '0;
		record_key = '0;
		record_handle = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: pops report empty, sort does nothing
		send_item(OP_POP_FRONT, 32'sd0, 16'h0000);
		send_item(OP_POP_BACK, 32'sd0, 16'h0000);
		send_item(OP_SORT, 32'sd0, 16'h0000);
		send_item(OP_PUSH_BACK, 32'sh7fffffff, 16'hffff);
		send_item(OP_SORT, 32'sd0, 16'h0000);
		send_item(OP_PUSH_FRONT, 32'sh80000000, 16'h0000);
		send_item(OP_SORT, 32'sd0, 16'h0000);
		// equal keys must keep their order through the sort
		send_item(OP_PUSH_BACK, 32'sd7, 16'h0011);
		send_item(OP_PUSH_BACK, -32'sd1, 16'h0022);
		send_item(OP_PUSH_FRONT, 32'sd7, 16'h0033);
		send_item(OP_PUSH_BACK, 32'sd7, 16'h0044);
		send_item(OP_SORT, 32'sd0, 16'h0000);
		send_item(OP_POP_FRONT, 32'sd0, 16'h0000);
		send_item(OP_POP_BACK, 32'sd0, 16'h0000);
		// unused opcodes are ignored
		send_item(3'd5, 32'sd0, 16'h0000);
		send_item(3'd6, -32'sd1, 16'hffff);
		send_item(3'd7, 32'sh7fffffff, 16'hffff);
		send_item(OP_POP_FRONT, 32'sd0, 16'h0000);
		send_item(OP_POP_FRONT, 32'sd0, 16'h0000);
		send_item(OP_POP_BACK, 32'sd0, 16'h0000);
		send_item(OP_POP_BACK, 32'sd0, 16'h0000);
		send_item(OP_POP_FRONT, 32'sd0, 16'h0000);

		mode = CHURN;
		mode_left = 0;
		for (int n = 0; n < RAND_COUNT; n++) begin
			calm = (n >= RAND_COUNT - CALM_TAIL);
			if (mode_left == 0) begin
				mode = traffic_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 60);
			end
			mode_left--;
			case (mode)
				FILL_UP: begin
					w_sort = 14; w_front = 50; w_back = 85; w_popf = 93;
				end
				DRAIN_DOWN: begin
					w_sort = 12; w_front = 19; w_back = 26; w_popf = 63;
				end
				default: begin
					w_sort = 12; w_front = 34; w_back = 56; w_popf = 78;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 2)
				op = OP_W'($urandom_range(5, 7));
			else if (pick < w_sort)
				op = OP_SORT;
			else if (pick < w_front)
				op = OP_PUSH_FRONT;
			else if (pick < w_back)
				op = OP_PUSH_BACK;
			else if (pick < w_popf)
				op = OP_POP_FRONT;
			else
				op = OP_POP_BACK;
			// narrow keys give many ties for the stability check
			case ($urandom_range(0, 3))
				0: key = int'($urandom_range(0, 8)) - 4;
				1: begin
					case ($urandom_range(0, 3))
						0: key = 32'sh7fffffff;
						1: key = 32'sh80000000;
						2: key = '0;
						default: key = '1;
					endcase
				end
				default: key = $urandom;
			endcase
			if ($urandom_range(0, 9) == 0)
				handle = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			else
				handle = HANDLE_W'($urandom_range(0, 65535));
			send_item(op, key, handle);
		end
		in_valid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("record_deque_with_key_sort verification clean");
		else
			$display("record_deque_with_key_sort verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/rdq_pkg.sv
hdl/rdq_cell.sv
hdl/rdq_ctrl.sv
hdl/record_deque_with_key_sort.sv
sim/rdq_tb_pkg.sv
sim/tb_top.sv
